/* hw/rtl/ipcmb_pkg.sv */
// ipcmb_pkg: call kinds, status codes and the result record of the mailbox engine
// no dependencies; imported by ipc_mailbox_reply_token_engine
package ipcmb_pkg;

   // call kinds
   localparam logic [2:0] KIND_SEND    = 3'd0;
   localparam logic [2:0] KIND_RECV    = 3'd1;
   localparam logic [2:0] KIND_REPLY   = 3'd2;
   localparam logic [2:0] KIND_POLL    = 3'd3;
   localparam logic [2:0] KIND_CLEANUP = 3'd4;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_NOPEER   = 3'd2;
   localparam logic [2:0] ST_BLOCK    = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   // one result, without the message body
   typedef struct packed {
      logic [2:0]  status;
      logic        wake_valid;
      logic [4:0]  wake_task;
      logic        caller_blocked;
      logic        msg_valid;
      logic [4:0]  msg_from;
      logic [15:0] msg_token;
      logic        has_message;
      logic        last;
   } rsp_type;

endpackage

/* hw/rtl/ipcmb_ram.sv */
// ipcmb_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the queue and slot stores of the mailbox engine
module ipcmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hw/rtl/ipc_mailbox_reply_token_engine.sv */
// ipc_mailbox_reply_token_engine: per-task ring mailboxes with send, receive, reply,
// poll and dead-service cleanup; depends on ipcmb_pkg and ipcmb_ram
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  kind caller target target_alive reply_token payload
//   rsp_     out        rsp_valid/rsp_stall  status wake_* caller_blocked msg_* has_message last
//
// one call is worked at a time by a sequencer around the slot and queue rams
// send, receive and poll read the queue entry once and emit one result; reply scans the
// caller's slots for the token, and cleanup scans the target's slots, one result per answered client
// after reset a clearing pass over all TASKS*QUEUE_DEPTH (power-of-two rounded) slots runs
// a held result sits in the output register while the next call is accepted
module ipc_mailbox_reply_token_engine
   import ipcmb_pkg::*;
#(
   parameter int TASKS        = 32,
   parameter int QUEUE_DEPTH  = 32,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_kind,
   input  logic [4:0]              req_caller,
   input  logic [7:0]              req_target,
   input  logic                    req_target_alive,
   input  logic [15:0]             req_reply_token,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic                    rsp_wake_valid,
   output logic [4:0]              rsp_wake_task,
   output logic                    rsp_caller_blocked,
   output logic                    rsp_msg_valid,
   output logic [4:0]              rsp_msg_from,
   output logic [15:0]             rsp_msg_token,
   output logic [PAYLOAD_BITS-1:0] rsp_msg_payload,
   output logic                    rsp_has_message,
   output logic                    rsp_last
);

   localparam int TW  = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int AW  = TW + QW;
   localparam int CW  = QW + 1;
   localparam int QEW = 2 * QW + CW;
   localparam int SDW = PAYLOAD_BITS + 5;
   localparam logic [CW-1:0] QFULL = CW'(QUEUE_DEPTH);
   localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_CHECK    = 4'd2;
   localparam logic [3:0] S_SEND     = 4'd3;
   localparam logic [3:0] S_QCALL    = 4'd4;
   localparam logic [3:0] S_RECV     = 4'd5;
   localparam logic [3:0] S_SCAN_RD  = 4'd6;
   localparam logic [3:0] S_SCAN_CHK = 4'd7;
   localparam logic [3:0] S_RPLY_Q   = 4'd8;
   localparam logic [3:0] S_RPLY_CLR = 4'd9;
   localparam logic [3:0] S_CLN_Q    = 4'd10;
   localparam logic [3:0] S_CLN_END  = 4'd11;
   localparam logic [3:0] S_EMIT     = 4'd12;

   function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] i);
      return (i == QLAST) ? '0 : i + 1'b1;
   endfunction

   // control registers
   logic [3:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [QW-1:0]    idx_ff, idx_in;
   logic [15:0]      tc_ff, tc_in;
   logic [TASKS-1:0] send_w_ff, send_w_in;
   logic [TASKS-1:0] recv_w_ff, recv_w_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [2:0]              kind_ff;
   logic [4:0]              caller_ff;
   logic [7:0]              target_ff;
   logic                    alive_ff;
   logic [15:0]             rtok_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [4:0]              client_ff, client_in;
   logic [15:0]             ctok_ff, ctok_in;
   rsp_type                 res_ff, res_in;
   logic [PAYLOAD_BITS-1:0] res_pay_ff, res_pay_in;
   rsp_type                 out_ff;
   logic [PAYLOAD_BITS-1:0] out_pay_ff;

   // ram ports
   logic           q_we, q_re, s_re, d_we, t_we, i_we;
   logic [TW-1:0]  q_waddr, q_raddr;
   logic [QEW-1:0] q_wdata, q_rd;
   logic [AW-1:0]  s_waddr, s_raddr;
   logic [SDW-1:0] d_wdata, d_rd;
   logic [15:0]    t_wdata, t_rd;
   logic           i_wdata, i_rd;

   logic [TW-1:0] me, tg, client;
   logic [QW-1:0] q_head, q_tail;
   logic [CW-1:0] q_count;
   logic [4:0]    rd_sender;
   logic          accept, out_free;
   logic [15:0]   tok_next;

   assign me        = TW'(caller_ff);
   assign tg        = TW'(target_ff);
   assign client    = TW'(client_ff);
   assign q_head    = q_rd[QEW-1 -: QW];
   assign q_tail    = q_rd[CW+QW-1 -: QW];
   assign q_count   = q_rd[CW-1:0];
   assign rd_sender = d_rd[SDW-1 -: 5];
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tok_next  = (tc_ff == 16'hFFFF) ? 16'd1 : tc_ff + 16'd1;
   assign req_stall = (state_ff != S_IDLE);

   // per-task queue pointers and counts
   ipcmb_ram #(.WIDTH(QEW), .DEPTH(2 ** TW)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_en(q_re), .rd_addr(q_raddr), .rd_data(q_rd)
   );

   // slot sender and body
   ipcmb_ram #(.WIDTH(SDW), .DEPTH(2 ** AW)) u_data_ram (
      .clock(clock), .wr_en(d_we), .wr_addr(s_waddr), .wr_data(d_wdata),
      .rd_en(s_re), .rd_addr(s_raddr), .rd_data(d_rd)
   );

   // slot reply tokens
   ipcmb_ram #(.WIDTH(16), .DEPTH(2 ** AW)) u_token_ram (
      .clock(clock), .wr_en(t_we), .wr_addr(s_waddr), .wr_data(t_wdata),
      .rd_en(s_re), .rd_addr(s_raddr), .rd_data(t_rd)
   );

   // slot inflight marks
   ipcmb_ram #(.WIDTH(1), .DEPTH(2 ** AW)) u_inflight_ram (
      .clock(clock), .wr_en(i_we), .wr_addr(s_waddr), .wr_data(i_wdata),
      .rd_en(s_re), .rd_addr(s_raddr), .rd_data(i_rd)
   );

   // call sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      tc_in        = tc_ff;
      send_w_in    = send_w_ff;
      recv_w_in    = recv_w_ff;
      client_in    = client_ff;
      ctok_in      = ctok_ff;
      res_in       = res_ff;
      res_pay_in   = res_pay_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_we = 1'b0; q_re = 1'b0; q_waddr = '0; q_raddr = '0; q_wdata = '0;
      s_re = 1'b0; d_we = 1'b0; t_we = 1'b0; i_we = 1'b0;
      s_waddr = '0; s_raddr = '0; d_wdata = '0; t_wdata = '0; i_wdata = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            t_we    = 1'b1;
            i_we    = 1'b1;
            s_waddr = clr_ff;
            q_we    = 1'b1;
            q_waddr = clr_ff[TW-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_in     = '0;
            res_in.last = 1'b1;
            res_pay_in = '0;
            idx_in     = '0;
            if (kind_ff == KIND_CLEANUP) begin
               if (32'(target_ff) >= TASKS) begin
                  res_in.status = ST_INVALID;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end else if (kind_ff > KIND_CLEANUP || 32'(caller_ff) >= TASKS) begin
               res_in.status = ST_INVALID;
               state_in = S_EMIT;
            end else if (kind_ff == KIND_SEND || kind_ff == KIND_REPLY) begin
               if (32'(target_ff) >= TASKS || target_ff == {3'b0, caller_ff}) begin
                  res_in.status = ST_INVALID;
                  state_in = S_EMIT;
               end else if (kind_ff == KIND_REPLY && rtok_ff == 16'd0) begin
                  res_in.status = ST_INVALID;
                  state_in = S_EMIT;
               end else if (!alive_ff) begin
                  res_in.status = ST_NOPEER;
                  state_in = S_EMIT;
               end else if (kind_ff == KIND_SEND) begin
                  q_re = 1'b1;
                  q_raddr = tg;
                  state_in = S_SEND;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end else begin
               q_re = 1'b1;
               q_raddr = me;
               state_in = S_QCALL;
            end
         end
         S_SEND: begin
            if (q_count == QFULL) begin
               res_in.status = ST_OVERFLOW;
            end else begin
               tc_in   = tok_next;
               s_waddr = {tg, q_tail};
               d_we    = 1'b1;
               d_wdata = {caller_ff, pay_ff};
               t_we    = 1'b1;
               t_wdata = tok_next;
               i_we    = 1'b1;
               i_wdata = 1'b1;
               q_we    = 1'b1;
               q_waddr = tg;
               q_wdata = {q_head, next_slot(q_tail), q_count + 1'b1};
               if (recv_w_ff[tg]) begin
                  recv_w_in[tg]     = 1'b0;
                  res_in.wake_valid = 1'b1;
                  res_in.wake_task  = 5'(tg);
               end
               send_w_in[me]         = 1'b1;
               res_in.caller_blocked = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_QCALL: begin
            if (kind_ff == KIND_POLL) begin
               res_in.has_message = (q_count != '0);
               state_in = S_EMIT;
            end else if (q_count == '0) begin
               recv_w_in[me]         = 1'b1;
               res_in.status         = ST_BLOCK;
               res_in.caller_blocked = 1'b1;
               state_in = S_EMIT;
            end else begin
               s_re    = 1'b1;
               s_raddr = {me, q_head};
               q_we    = 1'b1;
               q_waddr = me;
               q_wdata = {next_slot(q_head), q_tail, q_count - 1'b1};
               recv_w_in[me] = 1'b0;
               state_in = S_RECV;
            end
         end
         S_RECV: begin
            res_in.msg_valid = 1'b1;
            res_in.msg_from  = rd_sender;
            res_in.msg_token = t_rd;
            res_pay_in       = d_rd[PAYLOAD_BITS-1:0];
            state_in = S_EMIT;
         end
         S_SCAN_RD: begin
            s_re    = 1'b1;
            s_raddr = (kind_ff == KIND_REPLY) ? {me, idx_ff} : {tg, idx_ff};
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (kind_ff == KIND_REPLY) begin
               if (i_rd && t_rd == rtok_ff) begin
                  q_re = 1'b1;
                  q_raddr = tg;
                  state_in = S_RPLY_Q;
               end else if (idx_ff == QLAST) begin
                  res_in.status = ST_INVALID;
                  state_in = S_EMIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end
            end else begin
               // answered slot: drop its mark, then serve the client if it exists
               if (i_rd) begin
                  s_waddr   = {tg, idx_ff};
                  t_we      = 1'b1;
                  i_we      = 1'b1;
                  client_in = rd_sender;
                  ctok_in   = t_rd;
               end
               if (i_rd && 32'(rd_sender) < TASKS) begin
                  q_re = 1'b1;
                  q_raddr = TW'(rd_sender);
                  state_in = S_CLN_Q;
               end else if (idx_ff == QLAST) begin
                  state_in = S_CLN_END;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_RPLY_Q: begin
            if (q_count == QFULL) begin
               res_in.status = ST_OVERFLOW;
               state_in = S_EMIT;
            end else begin
               s_waddr = {tg, q_tail};
               d_we    = 1'b1;
               d_wdata = {caller_ff, pay_ff};
               t_we    = 1'b1;
               t_wdata = rtok_ff;
               q_we    = 1'b1;
               q_waddr = tg;
               q_wdata = {q_head, next_slot(q_tail), q_count + 1'b1};
               if (send_w_ff[tg]) begin
                  send_w_in[tg]     = 1'b0;
                  res_in.wake_valid = 1'b1;
                  res_in.wake_task  = 5'(tg);
               end
               state_in = S_RPLY_CLR;
            end
         end
         S_RPLY_CLR: begin
            s_waddr = {me, idx_ff};
            t_we    = 1'b1;
            i_we    = 1'b1;
            state_in = S_EMIT;
         end
         S_CLN_Q: begin
            res_in      = '0;
            res_pay_in  = '0;
            if (q_count == QFULL) begin
               res_in.status = ST_OVERFLOW;
            end else begin
               s_waddr = {client, q_tail};
               d_we    = 1'b1;
               d_wdata = {5'(tg), {PAYLOAD_BITS{1'b1}}};
               t_we    = 1'b1;
               t_wdata = ctok_ff;
               q_we    = 1'b1;
               q_waddr = client;
               q_wdata = {q_head, next_slot(q_tail), q_count + 1'b1};
            end
            if (send_w_ff[client]) begin
               send_w_in[client] = 1'b0;
               res_in.wake_valid = 1'b1;
               res_in.wake_task  = client_ff;
            end
            state_in = S_EMIT;
         end
         S_CLN_END: begin
            q_we        = 1'b1;
            q_waddr     = tg;
            res_in      = '0;
            res_in.last = 1'b1;
            res_pay_in  = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (res_ff.last) begin
                  state_in = S_IDLE;
               end else if (idx_ff == QLAST) begin
                  state_in = S_CLN_END;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         tc_ff        <= '0;
         send_w_ff    <= '0;
         recv_w_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         tc_ff        <= tc_in;
         send_w_ff    <= send_w_in;
         recv_w_ff    <= recv_w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // call fields, working result and output register
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         caller_ff <= req_caller;
         target_ff <= req_target;
         alive_ff  <= req_target_alive;
         rtok_ff   <= req_reply_token;
         pay_ff    <= req_payload;
      end
      client_ff  <= client_in;
      ctok_ff    <= ctok_in;
      res_ff     <= res_in;
      res_pay_ff <= res_pay_in;
      if (state_ff == S_EMIT && out_free) begin
         out_ff     <= res_ff;
         out_pay_ff <= res_pay_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_wake_valid     = out_ff.wake_valid;
   assign rsp_wake_task      = out_ff.wake_task;
   assign rsp_caller_blocked = out_ff.caller_blocked;
   assign rsp_msg_valid      = out_ff.msg_valid;
   assign rsp_msg_from       = out_ff.msg_from;
   assign rsp_msg_token      = out_ff.msg_token;
   assign rsp_msg_payload    = out_pay_ff;
   assign rsp_has_message    = out_ff.has_message;
   assign rsp_last           = out_ff.last;

endmodule

/* tb/sv/tb_ipc_mailbox_reply_token_engine.sv */
// tb_ipc_mailbox_reply_token_engine: self-checking bench for the mailbox engine, with its
// own mailbox predictor, random request idling and random and held result back-pressure
// depends on ipcmb_pkg and ipc_mailbox_reply_token_engine
module tb_ipc_mailbox_reply_token_engine;
   import ipcmb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NTASK  = 32;
   localparam int DEPTH  = 32;
   localparam int LIMIT  = 3_000_000;
   localparam logic [63:0] ERR_BODY = '1;

   typedef struct {
      logic [2:0]  status;
      logic        wake_valid;
      logic [4:0]  wake_task;
      logic        blocked;
      logic        msg_valid;
      logic [4:0]  msg_from;
      logic [15:0] msg_token;
      logic [63:0] msg_payload;
      logic        has_msg;
      logic        last;
   } call_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [4:0]  req_caller = '0;
   logic [7:0]  req_target = '0;
   logic        req_target_alive = 1'b0;
   logic [15:0] req_reply_token = '0;
   logic [63:0] req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_wake_valid;
   logic [4:0]  rsp_wake_task;
   logic        rsp_caller_blocked;
   logic        rsp_msg_valid;
   logic [4:0]  rsp_msg_from;
   logic [15:0] rsp_msg_token;
   logic [63:0] rsp_msg_payload;
   logic        rsp_has_message;
   logic        rsp_last;

   // mailbox state mirror
   logic [63:0] mb_payload [NTASK][DEPTH];
   logic [4:0]  mb_sender [NTASK][DEPTH];
   logic [15:0] mb_token [NTASK][DEPTH];
   logic        mb_inflight [NTASK][DEPTH];
   int          mb_head [NTASK];
   int          mb_tail [NTASK];
   int          mb_count [NTASK];
   logic [15:0] mb_token_ctr;
   logic        mb_send_wait [NTASK];
   logic        mb_recv_wait [NTASK];

   call_result_t pending_results [$];
   int  errors = 0;
   int  cycles = 0;
   int  idle_pct = 0;
   int  stall_pct = 0;
   int  hold_req = 0;
   int  hold_left = 0;

   ipc_mailbox_reply_token_engine u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_caller(req_caller), .req_target(req_target),
      .req_target_alive(req_target_alive), .req_reply_token(req_reply_token),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_wake_valid(rsp_wake_valid),
      .rsp_wake_task(rsp_wake_task), .rsp_caller_blocked(rsp_caller_blocked),
      .rsp_msg_valid(rsp_msg_valid), .rsp_msg_from(rsp_msg_from),
      .rsp_msg_token(rsp_msg_token), .rsp_msg_payload(rsp_msg_payload),
      .rsp_has_message(rsp_has_message), .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_ipc_mailbox_reply_token_engine failed");
         $finish;
      end
   end

   // receiver stalls, with long hold-offs on request
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      end
   endfunction

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      call_result_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, status %0d", $time, rsp_status);
         end else begin
            e = pending_results.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("wake_valid", e.wake_valid, rsp_wake_valid);
            check_field("wake_task", e.wake_task, rsp_wake_task);
            check_field("caller_blocked", e.blocked, rsp_caller_blocked);
            check_field("msg_valid", e.msg_valid, rsp_msg_valid);
            check_field("msg_from", e.msg_from, rsp_msg_from);
            check_field("msg_token", e.msg_token, rsp_msg_token);
            check_field("msg_payload", e.msg_payload, rsp_msg_payload);
            check_field("has_message", e.has_msg, rsp_has_message);
            check_field("last", e.last, rsp_last);
         end
      end
   end

   function automatic call_result_t blank_result();
      call_result_t r;
      r = '{status: ST_OK, wake_valid: 0, wake_task: 0, blocked: 0, msg_valid: 0,
            msg_from: 0, msg_token: 0, msg_payload: 0, has_msg: 0, last: 0};
      return r;
   endfunction

   function automatic int mailbox_push(int t, logic [4:0] from, logic [15:0] tok,
                                       logic [63:0] body);
      int s;
      s = mb_tail[t];
      mb_payload[t][s] = body;
      mb_sender[t][s] = from;
      mb_token[t][s] = tok;
      mb_tail[t] = (s + 1) % DEPTH;
      mb_count[t]++;
      return s;
   endfunction

   // mailbox call predictor: queues the results one accepted call causes
   function automatic void predict_call(logic [2:0] kind, logic [4:0] caller,
                                        logic [7:0] target, logic alive,
                                        logic [15:0] tok, logic [63:0] body);
      call_result_t r, c;
      int t, s, hit;
      r = blank_result();
      r.last = 1'b1;
      t = target;
      if (kind == KIND_CLEANUP) begin
         if (target < NTASK) begin
            for (int i = 0; i < DEPTH; i++) begin
               if (mb_inflight[t][i]) begin
                  int client;
                  client = mb_sender[t][i];
                  c = blank_result();
                  mb_inflight[t][i] = 1'b0;
                  if (mb_count[client] >= DEPTH)
                     c.status = ST_OVERFLOW;
                  else
                     s = mailbox_push(client, t[4:0], mb_token[t][i], ERR_BODY);
                  mb_token[t][i] = '0;
                  if (mb_send_wait[client]) begin
                     mb_send_wait[client] = 1'b0;
                     c.wake_valid = 1'b1;
                     c.wake_task = client[4:0];
                  end
                  pending_results.push_back(c);
               end
            end
            mb_head[t] = 0;
            mb_tail[t] = 0;
            mb_count[t] = 0;
         end else begin
            r.status = ST_INVALID;
         end
      end else if (kind > KIND_CLEANUP) begin
         r.status = ST_INVALID;
      end else if (kind == KIND_SEND || kind == KIND_REPLY) begin
         if (target >= NTASK || target == caller) begin
            r.status = ST_INVALID;
         end else if (kind == KIND_REPLY && tok == 0) begin
            r.status = ST_INVALID;
         end else if (!alive) begin
            r.status = ST_NOPEER;
         end else if (kind == KIND_SEND) begin
            if (mb_count[t] >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               mb_token_ctr = mb_token_ctr + 16'd1;
               if (mb_token_ctr == 0)
                  mb_token_ctr = 16'd1;
               s = mailbox_push(t, caller, mb_token_ctr, body);
               mb_inflight[t][s] = 1'b1;
               if (mb_recv_wait[t]) begin
                  mb_recv_wait[t] = 1'b0;
                  r.wake_valid = 1'b1;
                  r.wake_task = t[4:0];
               end
               mb_send_wait[caller] = 1'b1;
               r.blocked = 1'b1;
            end
         end else begin
            hit = -1;
            for (int i = 0; i < DEPTH; i++)
               if (hit < 0 && mb_inflight[caller][i] && mb_token[caller][i] == tok)
                  hit = i;
            if (hit < 0) begin
               r.status = ST_INVALID;
            end else if (mb_count[t] >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               mb_inflight[caller][hit] = 1'b0;
               mb_token[caller][hit] = '0;
               s = mailbox_push(t, caller, tok, body);
               if (mb_send_wait[t]) begin
                  mb_send_wait[t] = 1'b0;
                  r.wake_valid = 1'b1;
                  r.wake_task = t[4:0];
               end
            end
         end
      end else if (kind == KIND_RECV) begin
         if (mb_count[caller] == 0) begin
            mb_recv_wait[caller] = 1'b1;
            r.status = ST_BLOCK;
            r.blocked = 1'b1;
         end else begin
            s = mb_head[caller];
            r.msg_valid = 1'b1;
            r.msg_from = mb_sender[caller][s];
            r.msg_token = mb_token[caller][s];
            r.msg_payload = mb_payload[caller][s];
            mb_head[caller] = (s + 1) % DEPTH;
            mb_count[caller]--;
            mb_recv_wait[caller] = 1'b0;
         end
      end else begin
         r.has_msg = (mb_count[caller] != 0);
      end
      pending_results.push_back(r);
   endfunction

   // offer one call, with a random idle gap first, and predict it on transfer
   task automatic send_call(logic [2:0] kind, logic [4:0] caller, logic [7:0] target,
                            logic alive, logic [15:0] tok, logic [63:0] body);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_caller <= caller;
      req_target <= target;
      req_target_alive <= alive;
      req_reply_token <= tok;
      req_payload <= body;
      do
         @(posedge clock);
      while (req_stall);
      predict_call(kind, caller, target, alive, tok, body);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [63:0] rand_body();
      return {$urandom(), $urandom()};
   endfunction

   // one random call, mostly well formed among a small group of tasks
   task automatic random_call();
      int pick, c, t, slot;
      logic [15:0] tok;
      pick = $urandom_range(99);
      c = $urandom_range(5);
      t = $urandom_range(5);
      if (t == c)
         t = (c + 1) % 6;
      if (pick < 35) begin
         send_call(KIND_SEND, 5'(c), 8'(t), $urandom_range(19) != 0, '0, rand_body());
      end else if (pick < 60) begin
         send_call(KIND_RECV, 5'(c), 8'($urandom()), 1'($urandom()), 16'($urandom()),
                   rand_body());
      end else if (pick < 80) begin
         // answer an outstanding request when one is picked, else use a random token
         slot = -1;
         for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && mb_inflight[c][i] && $urandom_range(2) != 0)
               slot = i;
         if (slot >= 0 && $urandom_range(9) != 0)
            send_call(KIND_REPLY, 5'(c), 8'(mb_sender[c][slot]), 1'b1, mb_token[c][slot],
                      rand_body());
         else
            send_call(KIND_REPLY, 5'(c), 8'(t), 1'($urandom()), 16'($urandom()),
                      rand_body());
      end else if (pick < 88) begin
         send_call(KIND_POLL, 5'(c), 8'($urandom()), 1'($urandom()), 16'($urandom()),
                   rand_body());
      end else if (pick < 92) begin
         send_call(KIND_CLEANUP, 5'($urandom()), 8'($urandom_range(7)), 1'b0, '0,
                   rand_body());
      end else begin
         // noise: any kind, caller and target
         tok = 16'($urandom());
         send_call(3'($urandom()), 5'($urandom()), 8'($urandom()), 1'($urandom()), tok,
                   rand_body());
      end
   endtask

   task automatic test_directed();
      send_call(KIND_POLL, 5'd0, 8'd0, 1'b0, 16'd0, 64'd0);
      send_call(KIND_RECV, 5'd1, 8'd0, 1'b0, 16'd0, 64'd0);
      send_call(KIND_SEND, 5'd0, 8'd1, 1'b1, 16'hFFFF, '1);
      send_call(KIND_POLL, 5'd1, 8'hFF, 1'b1, 16'hFFFF, '1);
      send_call(KIND_RECV, 5'd1, 8'hFF, 1'b1, 16'hFFFF, '1);
      send_call(KIND_REPLY, 5'd1, 8'd0, 1'b1, 16'd1, 64'h0123_4567_89AB_CDEF);
      send_call(KIND_RECV, 5'd0, 8'd0, 1'b1, 16'd0, 64'd0);
      send_call(KIND_REPLY, 5'd1, 8'd0, 1'b1, 16'd0, 64'd0);
      send_call(KIND_REPLY, 5'd1, 8'd0, 1'b1, 16'd77, 64'd0);
      send_call(KIND_SEND, 5'd2, 8'd2, 1'b1, 16'd0, 64'd5);
      send_call(KIND_SEND, 5'd2, 8'd32, 1'b1, 16'd0, 64'd5);
      send_call(KIND_SEND, 5'd2, 8'd3, 1'b0, 16'd0, 64'd5);
      send_call(KIND_SEND, 5'd31, 8'd30, 1'b1, 16'd0, 64'hAA);
      send_call(KIND_SEND, 5'd2, 8'd30, 1'b1, 16'd0, 64'hBB);
      send_call(KIND_CLEANUP, 5'd0, 8'd30, 1'b0, 16'd0, 64'd0);
      send_call(KIND_CLEANUP, 5'd0, 8'd200, 1'b0, 16'd0, 64'd0);
      send_call(KIND_RECV, 5'd31, 8'd0, 1'b1, 16'd0, 64'd0);
      send_call(KIND_RECV, 5'd2, 8'd0, 1'b1, 16'd0, 64'd0);
      send_call(3'd5, 5'd0, 8'd1, 1'b1, 16'd0, 64'd0);
      send_call(3'd6, 5'd0, 8'd1, 1'b1, 16'd0, 64'd0);
      send_call(3'd7, 5'd31, 8'd255, 1'b1, 16'hFFFF, '1);
      wait_drained();
   endtask

   // full mailboxes: overflow on send and reply, and cleanup into a full client
   task automatic test_full_queues();
      send_call(KIND_SEND, 5'd10, 8'd9, 1'b1, 16'd0, 64'h10);
      for (int i = 0; i < DEPTH + 1; i++)
         send_call(KIND_SEND, 5'd11, 8'd10, 1'b1, 16'd0, rand_body());
      for (int i = 0; i < DEPTH; i++)
         send_call(KIND_SEND, 5'(12 + i % 4), 8'd9, 1'b1, 16'd0, rand_body());
      send_call(KIND_REPLY, 5'd10, 8'd11, 1'b1, mb_token[10][0], 64'd1);
      send_call(KIND_REPLY, 5'd9, 8'd10, 1'b1, mb_token[9][0], 64'd2);
      send_call(KIND_CLEANUP, 5'd0, 8'd9, 1'b0, 16'd0, 64'd0);
      send_call(KIND_CLEANUP, 5'd0, 8'd10, 1'b0, 16'd0, 64'd0);
      for (int i = 0; i < 6; i++)
         send_call(KIND_RECV, 5'(12 + i % 4), 8'd0, 1'b0, 16'd0, 64'd0);
      wait_drained();
   endtask

   task automatic test_random(int n, int idle, int stall);
      idle_pct = idle;
      stall_pct = stall;
      repeat (n) random_call();
      wait_drained();
      idle_pct = 0;
      stall_pct = 0;
   endtask

   // long receiver hold-off while calls keep coming, then a full pause
   task automatic test_backpressure();
      hold_req = 400;
      repeat (30) random_call();
      wait_drained();
      repeat (20) @(posedge clock);
      repeat (20) random_call();
      wait_drained();
   endtask

   initial begin
      for (int t = 0; t < NTASK; t++) begin
         mb_head[t] = 0;
         mb_tail[t] = 0;
         mb_count[t] = 0;
         mb_send_wait[t] = 1'b0;
         mb_recv_wait[t] = 1'b0;
         for (int s = 0; s < DEPTH; s++) begin
            mb_token[t][s] = '0;
            mb_inflight[t][s] = 1'b0;
         end
      end
      mb_token_ctr = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_queues();
      test_random(60, 0, 0);
      test_random(50, 66, 0);
      test_random(50, 0, 66);
      test_random(50, 38, 38);
      test_backpressure();
      test_random(20, 0, 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("tb_ipc_mailbox_reply_token_engine passed");
      else
         $display("tb_ipc_mailbox_reply_token_engine failed");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ipcmb_pkg.sv
hw/rtl/ipcmb_ram.sv
hw/rtl/ipc_mailbox_reply_token_engine.sv
tb/sv/tb_ipc_mailbox_reply_token_engine.sv
